/* rtl/lfe_pkg.sv */
// Shared types, constants and codes for the link frame encoder.
package lfe_pkg;

    localparam int C_COUNT_FRAME_BYTES = 3;
    localparam int C_FLAG_FRAME_BYTES  = 5;

    // A job holds every byte one transaction puts on the line.
    localparam int C_JOB_BYTES = (C_COUNT_FRAME_BYTES + 1 > 3) ? C_COUNT_FRAME_BYTES + 1 : 3;
    localparam int C_IDX_W     = $clog2(C_JOB_BYTES);
    localparam int C_BIF_W     = 3;
    localparam int C_RUN_W     = 3;

    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QPTR_W      = $clog2(C_QUEUE_DEPTH);
    localparam int C_QCNT_W      = $clog2(C_QUEUE_DEPTH + 1);

    localparam logic [C_BIF_W-1:0] C_COUNT_LIMIT = C_BIF_W'(C_COUNT_FRAME_BYTES);
    localparam logic [C_BIF_W-1:0] C_FLAG_LIMIT  = C_BIF_W'(C_FLAG_FRAME_BYTES);
    localparam logic [C_RUN_W-1:0] C_STUFF_RUN   = 3'd5;
    localparam logic [7:0]         C_HDLC_FLAG   = 8'h7E;
    localparam logic [7:0]         C_DELIM_RESET = 8'h0F;

    localparam logic [1:0] MODE_CHAR_COUNT = 2'd0;
    localparam logic [1:0] MODE_BYTE_FLAG  = 2'd1;
    localparam logic [1:0] MODE_BIT_STUFF  = 2'd2;

    localparam logic CFG_FRAMING_MODE   = 1'b0;
    localparam logic CFG_DELIMITER_BYTE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_lfe_in;

    typedef struct packed {
        logic line_bit;
        logic frame_done;
        logic run_last;
    } t_lfe_out;

    typedef struct packed {
        logic [1:0] framing_mode;
        logic [7:0] delimiter_byte;
    } t_lfe_cfg;

    typedef struct packed {
        logic [C_JOB_BYTES-1:0][7:0] bytes;
        logic [C_JOB_BYTES-1:0]      stuff;
        logic [C_IDX_W-1:0]          last_idx;
        logic                        clear_run;
        logic                        closed;
    } t_lfe_job;

endpackage

/* rtl/link_frame_encoder_unit.sv */
// Top level of the link frame encoder: configuration registers, front end, queue, serializer.
// With the block idle, the first line bit of a transaction passes the queue, the job register
// and the output register. Throughput: one line bit per cycle while jobs are queued and the
// output is not stalled; a transaction causes no bits (byte only buffered, or unused mode),
// 8 to 25 in the flag modes, or 16 to 32 when a character count frame leaves.
// Reset (synchronous, active low) empties the queue, closes any frame, restores mode 0 and 0x0F.
module link_frame_encoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lfe_pkg::t_lfe_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lfe_pkg::t_lfe_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_wdata
);
    import lfe_pkg::*;

    // Configuration registers. They are to be written by the user only while the block is idle,
    // so the front end may read them directly; the block itself does not enforce this.
    t_lfe_cfg r_cfg;

    logic     in_accept;
    logic     front_push;
    t_lfe_job front_job;
    logic     queue_full;
    logic     queue_valid;
    t_lfe_job queue_job;
    logic     back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.framing_mode   <= MODE_CHAR_COUNT;
            r_cfg.delimiter_byte <= C_DELIM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAMING_MODE:   r_cfg.framing_mode   <= i_cfg_wdata[1:0];
                CFG_DELIMITER_BYTE: r_cfg.delimiter_byte <= i_cfg_wdata;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // The front end takes a transaction whenever the queue has room. A transaction
    // that only buffers a byte (character count, frame still open) updates frame state
    // and pushes nothing; one that arrives in the unused mode changes nothing.
    assign o_in_ready = !queue_full;
    assign in_accept  = i_in_valid && o_in_ready;

    lfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_push   (front_push),
        .o_job    (front_job)
    );

    // The queue decouples the two sides: while it has room, the front end keeps accepting
    // while the serializer works through a long job or waits on a stalled output.
    lfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_job   (queue_job)
    );

    // The serializer loads the next job in the same cycle it sends the last bit
    // of the current one, so consecutive jobs leave without a gap.
    lfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/lfe_front.sv */
// Front end: takes payload transactions, tracks the open frame and builds line jobs.
module lfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lfe_pkg::t_lfe_in  i_item,
    input  lfe_pkg::t_lfe_cfg i_cfg,
    output logic              o_push,
    output lfe_pkg::t_lfe_job o_job
);
    import lfe_pkg::*;

    logic [C_BIF_W-1:0] r_bytes_in_frame;
    logic [C_BIF_W-1:0] n_bytes_in_frame;
    logic [7:0]         r_held [C_COUNT_FRAME_BYTES];
    logic [C_BIF_W-1:0] slot;
    logic [C_BIF_W-1:0] cnt_new;
    logic               open_frame;
    logic               close_frame;
    logic               has_job;
    logic [7:0]         flag_byte;
    logic [C_IDX_W-1:0] data_pos;

    always_comb begin
        slot        = '0;
        cnt_new     = '0;
        open_frame  = 1'b0;
        close_frame = 1'b0;
        has_job     = 1'b0;
        data_pos    = '0;
        flag_byte   = (i_cfg.framing_mode == MODE_BYTE_FLAG) ? i_cfg.delimiter_byte : C_HDLC_FLAG;
        n_bytes_in_frame = r_bytes_in_frame;
        o_job       = '0;
        case (i_cfg.framing_mode)
            MODE_CHAR_COUNT: begin
                slot        = (r_bytes_in_frame >= C_COUNT_LIMIT) ? '0 : r_bytes_in_frame;
                cnt_new     = slot + C_BIF_W'(1);
                close_frame = (cnt_new >= C_COUNT_LIMIT) || i_item.end_of_message;
                has_job     = close_frame;
                n_bytes_in_frame = close_frame ? '0 : cnt_new;
                o_job.bytes[0] = 8'(cnt_new) + 8'd1;
                for (int k = 0; k < C_COUNT_FRAME_BYTES; k++) begin
                    o_job.bytes[k+1] = (C_BIF_W'(k) == slot) ? i_item.data_byte : r_held[k];
                end
                o_job.last_idx = C_IDX_W'(cnt_new);
                o_job.closed   = 1'b1;
            end
            MODE_BYTE_FLAG, MODE_BIT_STUFF: begin
                slot        = (r_bytes_in_frame >= C_FLAG_LIMIT) ? '0 : r_bytes_in_frame;
                open_frame  = (slot == '0);
                cnt_new     = slot + C_BIF_W'(1);
                close_frame = (cnt_new >= C_FLAG_LIMIT) || i_item.end_of_message;
                has_job     = 1'b1;
                n_bytes_in_frame = close_frame ? '0 : cnt_new;
                data_pos    = C_IDX_W'(open_frame);
                for (int k = 0; k < C_JOB_BYTES; k++) begin
                    o_job.bytes[k] = flag_byte;
                end
                o_job.bytes[data_pos] = i_item.data_byte;
                o_job.stuff[data_pos] = (i_cfg.framing_mode == MODE_BIT_STUFF);
                o_job.last_idx  = C_IDX_W'(open_frame) + C_IDX_W'(close_frame);
                o_job.clear_run = open_frame;
                o_job.closed    = close_frame;
            end
            default: begin
                has_job = 1'b0;
            end
        endcase
        o_push = i_accept && has_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_frame <= '0;
        end else if (i_accept) begin
            r_bytes_in_frame <= n_bytes_in_frame;
        end
    end

    // Buffered bytes carry no reset; only written entries are ever sent.
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_cfg.framing_mode == MODE_CHAR_COUNT)) begin
            for (int k = 0; k < C_COUNT_FRAME_BYTES; k++) begin
                if (C_BIF_W'(k) == slot) begin
                    r_held[k] <= i_item.data_byte;
                end
            end
        end
    end

endmodule

/* rtl/lfe_queue.sv */
// Short job queue between the front end and the serializer.
module lfe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfe_pkg::t_lfe_job i_job,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output lfe_pkg::t_lfe_job o_job
);
    import lfe_pkg::*;

    t_lfe_job            r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0] r_wr_ptr;
    logic [C_QPTR_W-1:0] r_rd_ptr;
    logic [C_QCNT_W-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    function automatic logic [C_QPTR_W-1:0] ptr_inc(input logic [C_QPTR_W-1:0] p);
        ptr_inc = (p == C_QPTR_W'(C_QUEUE_DEPTH - 1)) ? '0 : p + C_QPTR_W'(1);
    endfunction

    assign o_full  = (r_count == C_QCNT_W'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + C_QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - C_QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/lfe_back.sv */
// Back end: serializes queued jobs one line bit per cycle unless stalled, with bit stuffing.
module lfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  lfe_pkg::t_lfe_job i_job,
    output logic              o_job_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lfe_pkg::t_lfe_out o_out_data
);
    import lfe_pkg::*;

    logic               r_busy,       n_busy;
    t_lfe_job           r_job,        n_job;
    logic [C_IDX_W-1:0] r_byte_idx,   n_byte_idx;
    logic [2:0]         r_bit_idx,    n_bit_idx;
    logic               r_stuff_pend, n_stuff_pend;
    logic               r_pos_end,    n_pos_end;
    logic [C_RUN_W-1:0] r_ones_run,   n_ones_run;
    logic               r_out_valid,  n_out_valid;
    t_lfe_out           r_out_data,   n_out_data;

    logic               emit;
    logic               cur_bit;
    logic               last_bit;
    logic               final_pos;
    logic [C_RUN_W-1:0] run_inc;
    logic [C_RUN_W-1:0] run_after;
    logic               load;

    always_comb begin
        emit      = r_busy && (!r_out_valid || i_out_ready);
        final_pos = (r_byte_idx == r_job.last_idx) && (r_bit_idx == 3'd0);
        run_inc   = r_ones_run + C_RUN_W'(1);
        run_after = r_ones_run;

        n_byte_idx   = r_byte_idx;
        n_bit_idx    = r_bit_idx;
        n_stuff_pend = r_stuff_pend;
        n_pos_end    = r_pos_end;

        if (r_stuff_pend) begin
            cur_bit   = 1'b0;
            last_bit  = r_pos_end;
            run_after = '0;
            if (emit) begin
                n_stuff_pend = 1'b0;
            end
        end else begin
            cur_bit  = r_job.bytes[r_byte_idx][r_bit_idx];
            last_bit = final_pos;
            if (r_job.stuff[r_byte_idx]) begin
                if (cur_bit) begin
                    if (run_inc >= C_STUFF_RUN) begin
                        // Five ones in a row: a zero goes out next.
                        run_after = '0;
                        last_bit  = 1'b0;
                        if (emit) begin
                            n_stuff_pend = 1'b1;
                        end
                    end else begin
                        run_after = run_inc;
                    end
                end else begin
                    run_after = '0;
                end
            end
            if (emit) begin
                n_pos_end = final_pos;
                if (!final_pos) begin
                    n_bit_idx = r_bit_idx - 3'd1;
                    if (r_bit_idx == 3'd0) begin
                        n_byte_idx = r_byte_idx + C_IDX_W'(1);
                    end
                end
            end
        end

        n_ones_run = emit ? run_after : r_ones_run;
        load       = i_job_valid && (!r_busy || (emit && last_bit));
        o_job_pop  = load;

        n_busy = r_busy;
        n_job  = r_job;
        if (load) begin
            n_busy       = 1'b1;
            n_job        = i_job;
            n_byte_idx   = '0;
            n_bit_idx    = 3'd7;
            n_stuff_pend = 1'b0;
            n_pos_end    = 1'b0;
            if (i_job.clear_run) begin
                n_ones_run = '0;
            end
        end else if (emit && last_bit) begin
            n_busy = 1'b0;
        end

        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (emit) begin
            n_out_valid          = 1'b1;
            n_out_data.line_bit   = cur_bit;
            n_out_data.frame_done = last_bit && r_job.closed;
            n_out_data.run_last   = last_bit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_stuff_pend <= 1'b0;
            r_pos_end    <= 1'b0;
            r_ones_run   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_stuff_pend <= n_stuff_pend;
            r_pos_end    <= n_pos_end;
            r_ones_run   <= n_ones_run;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_byte_idx <= n_byte_idx;
        r_bit_idx  <= n_bit_idx;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/lfe_checker.sv */
// Port-level checks of the link frame encoder, bound to the top level.
module lfe_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input lfe_pkg::t_lfe_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input lfe_pkg::t_lfe_out o_out_data
);
    import lfe_pkg::*;

    // A payload transaction that waits keeps its valid and its data.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input transaction changed while waiting");

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // A frame ends only on the last bit that a payload transaction causes.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |-> o_out_data.run_last)
        else $error("frame ended before the end of a transaction's bits");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Reset empties the queue, so the input side is ready at once.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

endmodule

bind link_frame_encoder_unit lfe_checker u_lfe_checker (.*);
